### rtl/core/wsh_pkg.sv
// Shared types, constants and hash step functions for the word stream hash core.
`timescale 1ns / 1ps

package wsh_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned LEN_W  = 24;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [LEN_W-1:0]  len_t;

    // One finished (not yet avalanched) hash handed from front to queue
    typedef struct packed {
        logic  valid;
        hash_t hash;
    } push_t;

    // Mix one word into the running hash
    function automatic hash_t mix_word(hash_t h_in, half_t lo, half_t hi, logic skip_low);
        hash_t h1;
        hash_t t;
        hash_t h2;
        h1 = skip_low ? h_in : (h_in + {16'd0, lo});
        t  = {5'd0, hi, 11'd0} ^ h1;
        h2 = {h1[15:0], 16'd0} ^ t;
        return h2 + {11'd0, h2[31:11]};
    endfunction

    // First half of the avalanche: shift-xor 3, add >>5, shift-xor 4
    function automatic hash_t aval_first(hash_t h_in);
        hash_t h;
        h = h_in;
        h = h ^ {h[28:0], 3'd0};
        h = h + {5'd0, h[31:5]};
        h = h ^ {h[27:0], 4'd0};
        return h;
    endfunction

    // Second half of the avalanche: add >>17, shift-xor 25, add >>6
    function automatic hash_t aval_second(hash_t h_in);
        hash_t h;
        h = h_in;
        h = h + {17'd0, h[31:17]};
        h = h ^ {h[6:0], 25'd0};
        h = h + {6'd0, h[31:6]};
        return h;
    endfunction

endpackage

### rtl/core/word_stream_hash_core.sv
// Top level of the word stream hash core: front mixer, queue and avalanche back end.
// Throughput: one input beat per cycle while s_axis_tready is high; the front mixes a word
//   in the cycle it is accepted. A hash goes from the queue write through the first avalanche
//   half and the second avalanche half into the output register that drives m_axis_tvalid.
// s_axis_tready drops only when the queue holds FIFO_DEPTH hashes behind a stalled output.
// Reset (rst_n low, asynchronous) clears the running hash, palette mode, queue and valids.
`timescale 1ns / 1ps

module word_stream_hash_core
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,        // palette_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,     // [31:0] data_word, [55:32] byte_length
    input  logic        s_axis_tuser,     // first_word
    input  logic        s_axis_tlast,     // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata      // [31:0] hash_value
);

    wsh_pkg::push_t push;
    wsh_pkg::hash_t q_head;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           accept;

    assign s_axis_tready = ~q_full;
    assign accept        = s_axis_tvalid & ~q_full;

    wsh_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .data_word   (s_axis_tdata[31:0]),
        .byte_length (s_axis_tdata[55:32]),
        .first_word  (s_axis_tuser),
        .last_word   (s_axis_tlast),
        .push        (push)
    );

    wsh_queue
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    wsh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

### rtl/core/wsh_front.sv
// Front end: accepts input beats, seeds and mixes the running hash, pushes finished messages.
`timescale 1ns / 1ps

module wsh_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    input  logic              accept,
    input  wsh_pkg::hash_t    data_word,
    input  wsh_pkg::len_t     byte_length,
    input  logic              first_word,
    input  logic              last_word,
    output wsh_pkg::push_t    push
);

    logic           palette_mode_reg;
    wsh_pkg::hash_t running_hash_reg;
    wsh_pkg::hash_t running_hash_next;
    wsh_pkg::hash_t seed;

    // Pick the seed: byte length on a first word, else the running value
    assign seed = first_word ? {8'd0, byte_length} : running_hash_reg;

    assign running_hash_next = wsh_pkg::mix_word(seed, data_word[15:0], data_word[31:16],
                                                 first_word & palette_mode_reg);

    // Hand a finished message to the queue on its last beat
    assign push.valid = accept & last_word;
    assign push.hash  = running_hash_next;

    // Hold the config bit and the running hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_mode_reg <= 1'b0;
            running_hash_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                palette_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                running_hash_reg <= running_hash_next;
            end
        end
    end

endmodule

### rtl/core/wsh_queue.sv
// Short queue of mixed hashes between the front and the avalanche back end.
`timescale 1ns / 1ps

module wsh_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wsh_pkg::push_t    push,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output wsh_pkg::hash_t    head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsh_pkg::hash_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push.valid & ~full;
    assign do_pop  = pop & ~empty;

    // Advance pointers with wrap at the last entry
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.hash;
        end
    end

endmodule

### rtl/core/wsh_back.sv
// Back end: two-stage avalanche pipeline whose last stage is the output register.
`timescale 1ns / 1ps

module wsh_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  wsh_pkg::hash_t    q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output wsh_pkg::hash_t    out_hash
);

    logic           s1_valid_reg;
    logic           s2_valid_reg;
    wsh_pkg::hash_t s1_hash_reg;
    wsh_pkg::hash_t s2_hash_reg;
    logic           s1_ready;
    logic           s2_ready;

    // Each stage takes new data when empty or when it drains this cycle
    assign s2_ready  = ~s2_valid_reg | out_ready;
    assign s1_ready  = ~s1_valid_reg | s2_ready;
    assign q_pop     = s1_ready & ~q_empty;
    assign out_valid = s2_valid_reg;
    assign out_hash  = s2_hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= ~q_empty;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Advance payload through the two avalanche halves
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_hash_reg <= wsh_pkg::aval_first(q_head);
        end
        if (s2_ready)
        begin
            s2_hash_reg <= wsh_pkg::aval_second(s1_hash_reg);
        end
    end

endmodule

### rtl/core/wsh_checker.sv
// Port-level checker for the word stream hash core, bound to the top level.
`timescale 1ns / 1ps

module wsh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Output register is cleared while reset is held
    a_reset_clear: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("m_axis_tvalid high during reset");

    // Input backpressure only happens behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // A stalled result keeps its hash
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // A result leaves only through a handshake
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("output beat dropped without handshake");

endmodule

bind word_stream_hash_core wsh_checker u_wsh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
